// ===== rtl/spk_pkg.sv =====
// Shared types, register indexes and helpers for the Speck128/256 counter-mode cipher.
package spk_pkg;

  localparam int WORD_W  = 64;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 3;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [INDEX_W-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [INDEX_W-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [INDEX_W-1:0] REG_KEY_WORD3 = 3'd3;
  localparam logic [INDEX_W-1:0] REG_NONCE     = 3'd4;

  localparam int ROT_DATA = 8;
  localparam int ROT_KEY  = 3;

  typedef struct packed {
    logic [WORD_W-1:0]  data_lo;
    logic [WORD_W-1:0]  data_hi;
    logic [COUNT_W-1:0] byte_count;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0]  out_lo;
    logic [WORD_W-1:0]  out_hi;
    logic [COUNT_W-1:0] out_count;
    logic               out_last;
  } out_word_t;

  // State carried from one round cell to the next
  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] rk;
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s1;
    logic [WORD_W-1:0] s2;
    in_word_t          word;
  } cell_t;

  // Byte-lane mask: lane j of the low word is kept when count > j,
  // lane j of the high word when count > j + 8.
  function automatic logic [WORD_W-1:0] lane_mask(input logic [COUNT_W-1:0] count,
                                                  input logic               upper);
    logic [WORD_W-1:0] m;
    logic [COUNT_W-1:0] lim;
    m = '0;
    for (int j = 0; j < 8; j++) begin
      lim = upper ? COUNT_W'(j + 8) : COUNT_W'(j);
      m[j*8 +: 8] = (count > lim) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/spk_round_cell.sv =====
// One Speck round on the counter block and one key schedule round, registered.
module spk_round_cell #(
  parameter int ROUND_IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  spk_pkg::cell_t up_state,
  output logic          up_ready,
  output logic          valid,
  output spk_pkg::cell_t state,
  input  logic          down_ready
);
  import spk_pkg::*;

  cell_t             state_next;
  logic [WORD_W-1:0] x_new;
  logic [WORD_W-1:0] s_new;

  assign up_ready = !valid || down_ready;

  always_comb begin
    x_new = ({up_state.x[ROT_DATA-1:0], up_state.x[WORD_W-1:ROT_DATA]} + up_state.y)
            ^ up_state.rk;
    s_new = ({up_state.s0[ROT_DATA-1:0], up_state.s0[WORD_W-1:ROT_DATA]} + up_state.rk)
            ^ WORD_W'(ROUND_IDX);
    state_next      = up_state;
    state_next.x    = x_new;
    state_next.y    = {up_state.y[WORD_W-ROT_KEY-1:0], up_state.y[WORD_W-1:WORD_W-ROT_KEY]}
                      ^ x_new;
    state_next.rk   = {up_state.rk[WORD_W-ROT_KEY-1:0], up_state.rk[WORD_W-1:WORD_W-ROT_KEY]}
                      ^ s_new;
    // rotate the schedule words so the next cell always works on s0
    state_next.s0   = up_state.s1;
    state_next.s1   = up_state.s2;
    state_next.s2   = s_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/spk_out_stage.sv =====
// Output register: XOR keystream into the data word and zero the unused bytes.
module spk_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  spk_pkg::cell_t    up_state,
  output logic              up_ready,
  output logic              out_valid,
  output spk_pkg::out_word_t out_word,
  input  logic              out_stall
);
  import spk_pkg::*;

  out_word_t out_word_next;

  assign up_ready = !out_valid || !out_stall;

  always_comb begin
    out_word_next.out_lo    = (up_state.word.data_lo ^ up_state.y)
                              & lane_mask(up_state.word.byte_count, 1'b0);
    out_word_next.out_hi    = (up_state.word.data_hi ^ up_state.x)
                              & lane_mask(up_state.word.byte_count, 1'b1);
    out_word_next.out_count = up_state.word.byte_count;
    out_word_next.out_last  = up_state.word.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      out_word <= out_word_next;
    end
  end

endmodule

// ===== rtl/speck128_256_ctr_stream_cipher.sv =====
// Speck128/256 counter-mode stream cipher: top level with config, counter and round chain.
//
// Usage: each input word is a 16-byte chunk (data_lo/data_hi, byte_count, last) on the
// in channel; each output word is the chunk XOR keystream with bytes at or beyond
// byte_count zeroed, plus the copied count and last flag. Encryption and decryption are
// the same operation. Key words and nonce are written through the cfg port (index 0-3 key,
// 4 nonce) while no chunk is in flight; the user must ensure this, the block does not enforce it.
// The block counter is taken when a chunk is accepted, then advances by one, or returns
// to zero after a chunk with last set.
// Registers: one per round cell, then one output register.
// Throughput: one chunk per cycle while out_stall is low; each round cell does one data
// round and one key schedule round, and the chain of ROUNDS cells is fully pipelined.
// Reset clears the key, nonce, counter and every valid flag.
// When out_stall is high the output word holds; cells behind it keep filling any empty
// slots, and in_stall rises only once every cell and the output register are full.
module speck128_256_ctr_stream_cipher #(
  parameter int ROUNDS = 34
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  spk_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output spk_pkg::out_word_t              out_word,
  input  logic                            cfg_en,
  input  logic [spk_pkg::INDEX_W-1:0]     cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]      cfg_data
);
  import spk_pkg::*;

  logic [WORD_W-1:0] key_word0;
  logic [WORD_W-1:0] key_word1;
  logic [WORD_W-1:0] key_word2;
  logic [WORD_W-1:0] key_word3;
  logic [WORD_W-1:0] nonce;
  logic [WORD_W-1:0] block_counter;

  cell_t chain_state [ROUNDS+1];
  logic  chain_valid [ROUNDS+1];
  logic  chain_ready [ROUNDS+1];
  logic  in_accept;

  assign in_stall  = !chain_ready[0];
  assign in_accept = in_valid && chain_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word0 <= '0;
      key_word1 <= '0;
      key_word2 <= '0;
      key_word3 <= '0;
      nonce     <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_KEY_WORD0: key_word0 <= cfg_data;
        REG_KEY_WORD1: key_word1 <= cfg_data;
        REG_KEY_WORD2: key_word2 <= cfg_data;
        REG_KEY_WORD3: key_word3 <= cfg_data;
        REG_NONCE:     nonce     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (in_accept) begin
      block_counter <= in_word.last ? '0 : block_counter + WORD_W'(1);
    end
  end

  always_comb begin
    chain_valid[0]    = in_valid;
    chain_state[0].x  = block_counter;
    chain_state[0].y  = nonce;
    chain_state[0].rk = key_word0;
    chain_state[0].s0 = key_word1;
    chain_state[0].s1 = key_word2;
    chain_state[0].s2 = key_word3;
    chain_state[0].word = in_word;
  end

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    spk_round_cell #(
      .ROUND_IDX(r)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (chain_valid[r]),
      .up_state  (chain_state[r]),
      .up_ready  (chain_ready[r]),
      .valid     (chain_valid[r+1]),
      .state     (chain_state[r+1]),
      .down_ready(chain_ready[r+1])
    );
  end

  spk_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[ROUNDS]),
    .up_state (chain_state[ROUNDS]),
    .up_ready (chain_ready[ROUNDS]),
    .out_valid(out_valid),
    .out_word (out_word),
    .out_stall(out_stall)
  );

endmodule

// ===== rtl/spk_checker.sv =====
// Port-level checks for the Speck128/256 counter-mode cipher, bound to the top level.
module spk_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spk_pkg::out_word_t out_word
);
  import spk_pkg::*;

  // output channel must come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // input backpressure only when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output backpressure");

  // zero byte count gives an all-zero word
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_count == 5'd0 |-> out_word.out_lo == '0 && out_word.out_hi == '0)
    else $error("bytes set with zero byte count");

  // short chunks leave the high half zero
  a_short_hi: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.out_count <= 5'd8 |-> out_word.out_hi == '0)
    else $error("high half set on short chunk");

endmodule

bind speck128_256_ctr_stream_cipher spk_checker u_spk_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);

// ===== dv/spk_ctr_checker.sv =====
// Channel monitor that predicts each cipher word from the key, nonce and block counter and compares.
module spk_ctr_checker #(
  parameter int ROUNDS = 34
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  spk_pkg::in_word_t           in_word,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  spk_pkg::out_word_t          out_word,
  input  logic                        cfg_en,
  input  logic [spk_pkg::INDEX_W-1:0] cfg_index,
  input  logic [spk_pkg::WORD_W-1:0]  cfg_data,
  output int                          mismatches,
  output int                          pending
);
  import spk_pkg::*;

  logic [WORD_W-1:0] key0, key1, key2, key3, nonce_val, chunk_ctr;
  out_word_t         cipher_due[$];
  out_word_t         due_word;
  int                err_cnt = 0;

  function automatic logic [WORD_W-1:0] ror64(input logic [WORD_W-1:0] v, input int s);
    return (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] v, input int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  // Run the counter block through all rounds with the key expanded alongside, then mask.
  function automatic out_word_t ctr_chunk_cipher(input in_word_t w,
                                                input logic [WORD_W-1:0] k0, k1, k2, k3,
                                                input logic [WORD_W-1:0] nc, ctr);
    logic [WORD_W-1:0] x, y, rk, lo_keep, hi_keep;
    logic [WORD_W-1:0] sched[3];
    out_word_t         res;
    int                r, j, cnt;
    x = ctr;
    y = nc;
    rk = k0;
    sched[0] = k1;
    sched[1] = k2;
    sched[2] = k3;
    for (r = 0; r < ROUNDS; r++) begin
      x = (ror64(x, ROT_DATA) + y) ^ rk;
      y = rol64(y, ROT_KEY) ^ x;
      if (r + 1 < ROUNDS) begin
        sched[r % 3] = (ror64(sched[r % 3], ROT_DATA) + rk) ^ WORD_W'(r);
        rk = rol64(rk, ROT_KEY) ^ sched[r % 3];
      end
    end
    cnt = int'(w.byte_count);
    lo_keep = '0;
    hi_keep = '0;
    for (j = 0; j < 8; j++) begin
      if (cnt > j)     lo_keep[j*8 +: 8] = 8'hFF;
      if (cnt > j + 8) hi_keep[j*8 +: 8] = 8'hFF;
    end
    res.out_lo    = (w.data_lo ^ y) & lo_keep;
    res.out_hi    = (w.data_hi ^ x) & hi_keep;
    res.out_count = w.byte_count;
    res.out_last  = w.last;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key0 = '0;
      key1 = '0;
      key2 = '0;
      key3 = '0;
      nonce_val = '0;
      chunk_ctr = '0;
      cipher_due.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_KEY_WORD0: key0 = cfg_data;
          REG_KEY_WORD1: key1 = cfg_data;
          REG_KEY_WORD2: key2 = cfg_data;
          REG_KEY_WORD3: key3 = cfg_data;
          REG_NONCE:     nonce_val = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        cipher_due.push_back(ctr_chunk_cipher(in_word, key0, key1, key2, key3,
                                              nonce_val, chunk_ctr));
        // restart the counter at each message boundary
        chunk_ctr = in_word.last ? '0 : chunk_ctr + 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (cipher_due.size() == 0) begin
          $error("unexpected word: out_lo %h out_hi %h", out_word.out_lo, out_word.out_hi);
          err_cnt++;
        end else begin
          due_word = cipher_due.pop_front();
          if (out_word.out_lo !== due_word.out_lo) begin
            $error("out_lo: expected %h, actual %h", due_word.out_lo, out_word.out_lo);
            err_cnt++;
          end
          if (out_word.out_hi !== due_word.out_hi) begin
            $error("out_hi: expected %h, actual %h", due_word.out_hi, out_word.out_hi);
            err_cnt++;
          end
          if (out_word.out_count !== due_word.out_count) begin
            $error("out_count: expected %0d, actual %0d", due_word.out_count,
                   out_word.out_count);
            err_cnt++;
          end
          if (out_word.out_last !== due_word.out_last) begin
            $error("out_last: expected %0b, actual %0b", due_word.out_last, out_word.out_last);
            err_cnt++;
          end
        end
      end
    end
    pending    <= cipher_due.size();
    mismatches <= err_cnt;
  end

endmodule

// ===== dv/tb.sv =====
// Stimulus, configuration phases and verdict for the Speck128/256 counter-mode cipher.
module tb;
  import spk_pkg::*;

  localparam int ROUNDS     = 34;
  localparam int LATENCY    = ROUNDS + 2;
  localparam int QUIET_MAX  = 4000;
  localparam int FULL_CHUNK = 16;
  localparam int MAX_COUNT  = 31;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                cfg_en = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = REG_KEY_WORD0;
  logic [WORD_W-1:0]   cfg_data = '0;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  speck128_256_ctr_stream_cipher #(.ROUNDS(ROUNDS)) i_dut (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_en, .cfg_index, .cfg_data
  );

  spk_ctr_checker #(.ROUNDS(ROUNDS)) u_chk (
    .clk, .rst, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_en, .cfg_index, .cfg_data, .mismatches, .pending
  );

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else     out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_word_t make_chunk(input int cnt, input logic lst);
    in_word_t w;
    int       pick;
    pick = $urandom_range(19);
    w.data_lo    = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
    w.data_hi    = (pick == 2) ? '0 : (pick == 3) ? '1 : rand64();
    w.byte_count = COUNT_W'(cnt);
    w.last       = lst;
    return w;
  endfunction

  task automatic send_chunk(input in_word_t w);
    int   gap;
    logic stalled;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic send_message(input int n_chunks);
    int i;
    for (i = 0; i < n_chunks - 1; i++) send_chunk(make_chunk(FULL_CHUNK, 1'b0));
    send_chunk(make_chunk($urandom_range(1, FULL_CHUNK), 1'b1));
  endtask

  // Mostly well-formed messages, some stray chunks with any count and last flag.
  task automatic send_traffic(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_chunk(make_chunk($urandom_range(0, MAX_COUNT), 1'($urandom_range(1))));
        sent++;
      end else begin
        len = ($urandom_range(99) < 5) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        send_message(len);
        sent += len;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [WORD_W-1:0] k0, k1, k2, k3, nc);
    wait_drained();
    cfg_write(REG_KEY_WORD0, k0);
    cfg_write(REG_KEY_WORD1, k1);
    cfg_write(REG_KEY_WORD2, k2);
    cfg_write(REG_KEY_WORD3, k3);
    cfg_write(REG_NONCE, nc);
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 75;

    // Directed chunks under the reset key and nonce.
    send_chunk('{data_lo: '0, data_hi: '0, byte_count: COUNT_W'(FULL_CHUNK), last: 1'b0});
    send_chunk('{data_lo: '1, data_hi: '1, byte_count: COUNT_W'(FULL_CHUNK), last: 1'b0});
    send_chunk(make_chunk(0, 1'b0));           // zero byte count
    send_chunk(make_chunk(1, 1'b0));           // short chunk without last
    send_chunk(make_chunk(7, 1'b0));
    send_chunk(make_chunk(8, 1'b0));           // low word boundary
    send_chunk(make_chunk(9, 1'b0));
    send_chunk(make_chunk(15, 1'b0));
    send_chunk(make_chunk(FULL_CHUNK + 1, 1'b0));  // count above sixteen
    send_chunk(make_chunk(MAX_COUNT, 1'b0));
    send_chunk('{data_lo: '1, data_hi: '1, byte_count: COUNT_W'(FULL_CHUNK), last: 1'b1});
    send_message(4);
    send_chunk(make_chunk(1, 1'b1));
    send_chunk(make_chunk(0, 1'b1));
    send_chunk(make_chunk(MAX_COUNT, 1'b1));
    send_traffic(140);

    load_config('1, '1, '1, '1, '1);
    send_traffic(150);

    load_config(rand64(), rand64(), rand64(), rand64(), rand64());
    send_idle_pct = 75;
    recv_idle_pct = 31;
    send_traffic(300);

    load_config('0, '0, '0, '0, '1);
    send_traffic(60);

    load_config(rand64(), rand64(), rand64(), rand64(), rand64());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_traffic(280);

    wait_drained();
    if (mismatches == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
